/* hdl/lpr_pkg.sv */
package lpr_pkg;

    // fixed field widths
    localparam int PAGE_IN_W  = 16;
    localparam int SLOT_W     = 2;
    localparam int TOTAL_W    = 16;
    localparam int COUNT_W    = 16;
    localparam int CFG_W      = 3;
    localparam int CFG_RESET  = 3;

    // structure
    localparam int FRAMES     = 4;
    localparam int PAGE_BITS  = 16;
    localparam int PAGE_W     = (PAGE_BITS < PAGE_IN_W) ? PAGE_BITS : PAGE_IN_W;
    localparam int IDX_W      = (FRAMES > 1) ? $clog2(FRAMES) : 1;

    // output word layout, lowest bit up
    localparam int OUT_BITS   = 1 + SLOT_W + 1 + PAGE_IN_W + TOTAL_W + TOTAL_W;
    localparam int OUT_W      = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

    // search token walking down the frame chain
    typedef struct packed {
        logic              vld;
        logic [PAGE_W-1:0] page;
        logic              hit;
        logic [IDX_W-1:0]  hit_idx;
        logic [COUNT_W-1:0] best_cnt;
        logic [IDX_W-1:0]  best_idx;
        logic              best_vld;
        logic [PAGE_W-1:0] best_page;
    } t_token;

    // decision broadcast to every frame cell
    typedef struct packed {
        logic              vld;
        logic              hit;
        logic [IDX_W-1:0]  slot;
        logic [PAGE_W-1:0] page;
    } t_update;

    // low bits of a frame index as reported on the output
    function automatic logic [SLOT_W-1:0] slot_bits(input logic [IDX_W-1:0] idx);
        logic [IDX_W+SLOT_W-1:0] ext;
        ext = {{SLOT_W{1'b0}}, idx};
        return ext[SLOT_W-1:0];
    endfunction

endpackage

/* hdl/lfu_page_replacement_unit.sv */
// Least-frequently-used page replacement over a chain of frame cells. Each input word is a
// page reference; each output word reports hit or fault, the frame now holding the page, the
// evicted page if a resident one was replaced, and saturating hit and fault totals. A search
// token walks the chain one frame cell per clock; the next word can be taken only once the
// walk through all FRAMES cells is done, the finished search is latched and the update is
// committed to the chosen frame. A result waiting on the output does not stop the next word
// from being accepted, but it holds back the next commit. i_cfg_we writes frames_in_use
// (0 acts as 1, values above FRAMES act as FRAMES); write it only while the unit is idle.
module lfu_page_replacement_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // page_number[15:0]
    input  logic [lpr_pkg::PAGE_IN_W-1:0] i_s_axis_tdata,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    // was_hit[0], frame_slot[2:1], evicted_valid[3], evicted_page[19:4],
    // hit_total[35:20], fault_total[51:36], zero fill above
    output logic [lpr_pkg::OUT_W-1:0]     o_m_axis_tdata,
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    input  logic                          i_cfg_we,
    input  logic [lpr_pkg::CFG_W-1:0]     i_cfg_wdata
);
    import lpr_pkg::*;

    logic [CFG_W-1:0]   r_frames_in_use;
    logic               r_busy;
    t_token             r_pend;
    logic               r_pend_vld;
    logic [TOTAL_W-1:0] r_hits;
    logic [TOTAL_W-1:0] r_faults;
    logic               r_out_vld;
    logic [OUT_W-1:0]   r_out_data;

    logic               w_accept;
    logic               w_commit;
    t_token             w_in_tok;
    t_update            w_upd;
    t_token             w_tok [FRAMES+1];
    logic [FRAMES-1:0]  w_active;
    logic [TOTAL_W-1:0] n_hits;
    logic [TOTAL_W-1:0] n_faults;
    logic [SLOT_W-1:0]  w_slot;
    logic [PAGE_IN_W-1:0] w_ev_page;
    logic               w_ev_vld;

    assign o_s_axis_tready = !r_busy;
    assign w_accept        = i_s_axis_tvalid && !r_busy;
    assign w_commit        = r_pend_vld && (!r_out_vld || i_m_axis_tready);

    // fresh token for cell 0
    always_comb begin
        w_in_tok      = '0;
        w_in_tok.vld  = w_accept;
        w_in_tok.page = i_s_axis_tdata[PAGE_W-1:0];
    end
    assign w_tok[0] = w_in_tok;

    // decision sent back to the frames
    always_comb begin
        w_upd      = '0;
        w_upd.vld  = w_commit;
        w_upd.hit  = r_pend.hit;
        w_upd.slot = r_pend.hit ? r_pend.hit_idx : r_pend.best_idx;
        w_upd.page = r_pend.page;
    end

    // frame cell chain
    for (genvar g = 0; g < FRAMES; g++) begin : g_cell
        assign w_active[g] = (g == 0) || (32'(g) < 32'(r_frames_in_use));
        lpr_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_cell_idx (IDX_W'(g)),
            .i_active   (w_active[g]),
            .i_tok      (w_tok[g]),
            .i_upd      (w_upd),
            .o_tok      (w_tok[g+1])
        );
    end

    // result fields
    always_comb begin
        n_hits    = r_hits;
        n_faults  = r_faults;
        w_ev_vld  = 1'b0;
        w_ev_page = '0;
        if (r_pend.hit) begin
            if (r_hits != TOTAL_MAX) begin
                n_hits = r_hits + TOTAL_W'(1);
            end
        end else begin
            if (r_faults != TOTAL_MAX) begin
                n_faults = r_faults + TOTAL_W'(1);
            end
            if (r_pend.best_vld) begin
                w_ev_vld  = 1'b1;
                w_ev_page = PAGE_IN_W'(r_pend.best_page);
            end
        end
        w_slot = slot_bits(w_upd.slot);
    end

    // control, totals and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frames_in_use <= CFG_W'(CFG_RESET);
            r_busy          <= 1'b0;
            r_pend_vld      <= 1'b0;
            r_hits          <= '0;
            r_faults        <= '0;
            r_out_vld       <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_frames_in_use <= i_cfg_wdata;
            end
            if (w_accept) begin
                r_busy <= 1'b1;
            end
            if (w_tok[FRAMES].vld) begin
                r_pend_vld <= 1'b1;
            end
            if (w_commit) begin
                r_pend_vld <= 1'b0;
                r_busy     <= 1'b0;
                r_hits     <= n_hits;
                r_faults   <= n_faults;
                r_out_vld  <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_vld  <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_tok[FRAMES].vld) begin
            r_pend <= w_tok[FRAMES];
        end
        if (w_commit) begin
            r_out_data <= OUT_W'({n_faults, n_hits, w_ev_page, w_ev_vld, w_slot, r_pend.hit});
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = r_out_data;

endmodule

/* hdl/lpr_cell.sv */
module lpr_cell (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [lpr_pkg::IDX_W-1:0] i_cell_idx,
    input  logic                  i_active,
    input  lpr_pkg::t_token       i_tok,
    input  lpr_pkg::t_update      i_upd,
    output lpr_pkg::t_token       o_tok
);
    import lpr_pkg::*;

    logic [PAGE_W-1:0]  r_page;
    logic               r_valid;
    logic [COUNT_W-1:0] r_count;
    t_token             r_tok;
    t_token             n_tok;
    logic               w_first;
    logic               w_mine;

    assign w_first = (i_cell_idx == '0);
    assign w_mine  = i_upd.vld && (i_upd.slot == i_cell_idx);

    // match and running minimum for this frame
    always_comb begin
        n_tok = i_tok;
        if (i_active) begin
            if (!i_tok.hit && r_valid && (r_page == i_tok.page)) begin
                n_tok.hit     = 1'b1;
                n_tok.hit_idx = i_cell_idx;
            end
            if (w_first || (r_count < i_tok.best_cnt)) begin
                n_tok.best_cnt  = r_count;
                n_tok.best_idx  = i_cell_idx;
                n_tok.best_vld  = r_valid;
                n_tok.best_page = r_page;
            end
        end
    end

    // frame contents and token hand-off
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= 1'b0;
            r_count   <= '0;
            r_tok.vld <= 1'b0;
        end else begin
            r_tok <= n_tok;
            if (w_mine) begin
                if (i_upd.hit) begin
                    if (r_count != COUNT_MAX) begin
                        r_count <= r_count + COUNT_W'(1);
                    end
                end else begin
                    r_valid <= 1'b1;
                    r_count <= COUNT_W'(1);
                end
            end
        end
    end

    // page store needs no reset, it is only read when valid
    always_ff @(posedge i_clk) begin
        if (w_mine && !i_upd.hit) begin
            r_page <= i_upd.page;
        end
    end

    assign o_tok = r_tok;

endmodule

/* bench/tb.sv */
module tb;
    import lpr_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int RST_CYCLES    = 9;
    localparam int CYCLE_LIMIT   = 3_000_000;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = FRAMES + 6;
    localparam int RAND_PHASES   = 10;
    localparam int PHASE_WORDS   = 112;
    localparam int REPORT_MAX    = 10;

    // one result word, laid out as on o_m_axis_tdata (lowest field last)
    typedef struct packed {
        logic [OUT_W-OUT_BITS-1:0] fill;
        logic [TOTAL_W-1:0]        fault_total;
        logic [TOTAL_W-1:0]        hit_total;
        logic [PAGE_IN_W-1:0]      evicted_page;
        logic                      evicted_valid;
        logic [SLOT_W-1:0]         frame_slot;
        logic                      was_hit;
    } t_lfu_word;

    logic                 i_clk           = 1'b0;
    logic                 i_rst_n         = 1'b0;
    // page_number[15:0]
    logic [PAGE_IN_W-1:0] i_s_axis_tdata  = '0;
    logic                 i_s_axis_tvalid = 1'b0;
    logic                 o_s_axis_tready;
    // was_hit[0], frame_slot[2:1], evicted_valid[3], evicted_page[19:4],
    // hit_total[35:20], fault_total[51:36], zero fill above
    logic [OUT_W-1:0]     o_m_axis_tdata;
    logic                 o_m_axis_tvalid;
    logic                 i_m_axis_tready = 1'b0;
    logic                 i_cfg_we        = 1'b0;
    logic [CFG_W-1:0]     i_cfg_wdata     = '0;

    // predictor state
    logic [CFG_W-1:0]     frames_cfg = CFG_W'(CFG_RESET);
    logic [PAGE_W-1:0]    frame_page [FRAMES];
    logic                 frame_full [FRAMES];
    logic [COUNT_W-1:0]   use_cnt    [FRAMES];
    logic [TOTAL_W-1:0]   hits_total   = '0;
    logic [TOTAL_W-1:0]   faults_total = '0;

    logic [PAGE_IN_W-1:0] page_refs [$];
    t_lfu_word            pending_outcomes [$];
    t_lfu_word            got_word;
    t_lfu_word            want_word;

    logic word_taken     = 1'b0;
    bit   src_gaps_on    = 1'b1;
    bit   sink_stalls_on = 1'b1;
    int   gap_left       = 0;
    int   stall_left     = 0;
    int   hold_left      = 0;
    int   hold_req       = 0;
    int   hold_ack       = 0;
    int   fail_count     = 0;
    int   cycle_count    = 0;
    int   words_in       = 0;
    int   hits_out       = 0;
    int   faults_out     = 0;

    lfu_page_replacement_unit DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    // clock
    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // mostly short gaps, now and then a long one
    function automatic int gap_cycles(input bit allow_zero);
        int roll;
        roll = $urandom_range(0, 99);
        if (allow_zero && roll < 55)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // lfu lookup and update for one page reference
    function automatic t_lfu_word lfu_lookup(input logic [PAGE_IN_W-1:0] page_in);
        t_lfu_word          res;
        logic [PAGE_W-1:0]  page;
        logic [COUNT_W-1:0] least;
        logic               found;
        int                 live;
        int                 slot;
        int                 i;
        res   = '0;
        page  = page_in[PAGE_W-1:0];
        live  = int'(frames_cfg);
        if (live < 1)
            live = 1;
        if (live > FRAMES)
            live = FRAMES;
        found = 1'b0;
        slot  = 0;
        // lowest matching frame wins
        for (i = 0; i < live; i++) begin
            if (!found && frame_full[i] && frame_page[i] == page) begin
                found = 1'b1;
                slot  = i;
            end
        end
        if (found) begin
            if (use_cnt[slot] != COUNT_MAX)
                use_cnt[slot] = use_cnt[slot] + 1'b1;
            if (hits_total != TOTAL_MAX)
                hits_total = hits_total + 1'b1;
        end else begin
            // smallest count, ties to the lowest index
            least = use_cnt[0];
            slot  = 0;
            for (i = 1; i < live; i++) begin
                if (use_cnt[i] < least) begin
                    least = use_cnt[i];
                    slot  = i;
                end
            end
            if (frame_full[slot]) begin
                res.evicted_valid = 1'b1;
                res.evicted_page  = frame_page[slot];
            end
            frame_page[slot] = page;
            frame_full[slot] = 1'b1;
            use_cnt[slot]    = COUNT_W'(1);
            if (faults_total != TOTAL_MAX)
                faults_total = faults_total + 1'b1;
        end
        res.was_hit     = found;
        res.frame_slot  = slot[SLOT_W-1:0];
        res.hit_total   = hits_total;
        res.fault_total = faults_total;
        return res;
    endfunction

    // page driver, fed from page_refs
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else if (i_s_axis_tvalid && !word_taken) begin
            i_s_axis_tvalid <= 1'b1;
        end else if (gap_left != 0) begin
            gap_left        <= gap_left - 1;
            i_s_axis_tvalid <= 1'b0;
        end else if (page_refs.size() != 0) begin
            i_s_axis_tdata  <= page_refs.pop_front();
            i_s_axis_tvalid <= 1'b1;
            gap_left        <= src_gaps_on ? gap_cycles(1'b1) : 0;
        end else begin
            i_s_axis_tvalid <= 1'b0;
        end
    end

    // result receiver: random stalls plus an occasional long hold-off
    always @(negedge i_clk) begin
        if (hold_ack != hold_req) begin
            hold_ack        <= hold_req;
            hold_left       <= HOLD_CYCLES - 1;
            i_m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left       <= hold_left - 1;
            i_m_axis_tready <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left      <= stall_left - 1;
            i_m_axis_tready <= 1'b0;
        end else if (sink_stalls_on && $urandom_range(0, 99) < 25) begin
            stall_left      <= gap_cycles(1'b0) - 1;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= 1'b1;
        end
    end

    // monitor: config writes, accepted pages and result words
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            word_taken <= 1'b0;
        end else begin
            word_taken <= i_s_axis_tvalid && o_s_axis_tready;
            if (i_cfg_we)
                frames_cfg = i_cfg_wdata;
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                got_word = o_m_axis_tdata;
                if (got_word.was_hit)
                    hits_out++;
                else
                    faults_out++;
                if (pending_outcomes.size() == 0) begin
                    fail_count++;
                    if (fail_count <= REPORT_MAX)
                        $display("cycle %0d: unexpected result word %h", cycle_count,
                                 o_m_axis_tdata);
                end else begin
                    want_word = pending_outcomes.pop_front();
                    if (got_word.was_hit !== want_word.was_hit ||
                        got_word.frame_slot !== want_word.frame_slot ||
                        got_word.evicted_valid !== want_word.evicted_valid ||
                        got_word.evicted_page !== want_word.evicted_page ||
                        got_word.hit_total !== want_word.hit_total ||
                        got_word.fault_total !== want_word.fault_total ||
                        got_word.fill !== want_word.fill) begin
                        fail_count++;
                        if (fail_count <= REPORT_MAX) begin
                            $display("cycle %0d: mismatch", cycle_count);
                            $display("  expected hit=%0d slot=%0d ev=%0d/%h hits=%0d faults=%0d",
                                     want_word.was_hit, want_word.frame_slot,
                                     want_word.evicted_valid, want_word.evicted_page,
                                     want_word.hit_total, want_word.fault_total);
                            $display("  actual   hit=%0d slot=%0d ev=%0d/%h hits=%0d faults=%0d",
                                     got_word.was_hit, got_word.frame_slot,
                                     got_word.evicted_valid, got_word.evicted_page,
                                     got_word.hit_total, got_word.fault_total);
                            $display("  actual   fill=%h", got_word.fill);
                        end
                    end
                end
            end
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                pending_outcomes.push_back(lfu_lookup(i_s_axis_tdata));
                words_in++;
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                     pending_outcomes.size());
            $display("Verification failed");
            $finish;
        end
    end

    // wait until all pages are sent and answered, then let the pipeline settle
    task automatic wait_drained();
        @(posedge i_clk);
        while (page_refs.size() != 0 || i_s_axis_tvalid || pending_outcomes.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // frames_in_use write, only while idle
    task automatic write_frames(input logic [CFG_W-1:0] value);
        i_cfg_wdata <= value;
        i_cfg_we    <= 1'b1;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // stimulus
    initial begin
        logic [CFG_W-1:0]     cfg_plan [RAND_PHASES];
        logic [PAGE_IN_W-1:0] pool [8];
        logic [PAGE_IN_W-1:0] pg;
        int                   pool_n;
        int                   roll;
        int                   ph;
        int                   k;

        for (k = 0; k < FRAMES; k++) begin
            frame_page[k] = '0;
            frame_full[k] = 1'b0;
            use_cnt[k]    = '0;
        end
        cfg_plan = '{3'd4, 3'd1, 3'd3, 3'd2, 3'd4, 3'd0, 3'd7, 3'd5, 3'd6, 3'd4};
        sink_stalls_on = 1'b1;
        src_gaps_on    = 1'b1;

        repeat (RST_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset frame count: fill in order, hit, evict on count ties
        page_refs.push_back(16'h0000);
        page_refs.push_back(16'hFFFF);
        page_refs.push_back(16'h0000);
        page_refs.push_back(16'hA5A5);
        page_refs.push_back(16'h5A5A);
        page_refs.push_back(16'hFFFF);
        wait_drained();

        // zero acts as one frame; leaves a copy of a page in an idle frame
        write_frames(CFG_W'(0));
        page_refs.push_back(16'h1234);
        page_refs.push_back(16'h1234);
        page_refs.push_back(16'hFFFF);
        wait_drained();

        // duplicate page: lowest frame is the hit
        write_frames(CFG_W'(2));
        page_refs.push_back(16'hFFFF);
        page_refs.push_back(16'hA5A5);
        wait_drained();

        // all frames, idle frames kept their contents
        write_frames(CFG_W'(4));
        page_refs.push_back(16'hA5A5);
        page_refs.push_back(16'h8001);
        page_refs.push_back(16'h7FFE);
        wait_drained();

        // above the frame count acts as all frames
        write_frames(CFG_W'(7));
        page_refs.push_back(16'h0001);
        page_refs.push_back(16'h8000);
        wait_drained();

        // random phases: hot pool with random content, some near misses and noise
        for (ph = 0; ph < RAND_PHASES; ph++) begin
            write_frames(cfg_plan[ph]);
            src_gaps_on    = (ph != 0 && ph != 2);
            sink_stalls_on = (ph != 0 && ph != 2);
            pool_n = $urandom_range(1, 6);
            for (k = 0; k < pool_n; k++)
                pool[k] = PAGE_IN_W'($urandom);
            for (k = 0; k < PHASE_WORDS; k++) begin
                // sender pause half way until every result is back
                if (ph == 4 && k == PHASE_WORDS / 2)
                    wait_drained();
                roll = $urandom_range(0, 99);
                pg   = pool[$urandom_range(0, pool_n - 1)];
                if (roll >= 90)
                    pg = PAGE_IN_W'($urandom);
                else if (roll >= 80)
                    pg = pg ^ (16'h0001 << $urandom_range(0, 15));
                page_refs.push_back(pg);
            end
            // long receiver hold-off while the sender keeps offering
            if (ph == 2)
                hold_req++;
            wait_drained();
        end

        // back to three frames with idling on
        src_gaps_on    = 1'b1;
        sink_stalls_on = 1'b1;
        write_frames(CFG_W'(3));
        for (k = 0; k < 20; k++)
            page_refs.push_back((k % 3 == 0) ? 16'h3C3C : 16'($urandom));
        wait_drained();
        repeat (2 * SETTLE_CYCLES) @(posedge i_clk);

        if (pending_outcomes.size() != 0) begin
            fail_count++;
            $display("%0d expected results never arrived", pending_outcomes.size());
        end
        $display("%0d page words (%0d hits, %0d faults), frame counts 0..7 incl. live changes,",
                 words_in, hits_out, faults_out);
        $display("duplicate frames, random idling and a long output hold-off");
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
